// ----- rtl/sti_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sti_pkg
// Widths and result codes for the sphere / triangle intersection core.
// ============================================================================
package sti_pkg;

    // one coordinate, signed fixed point; three of them packed per vertex
    localparam int CB     = 16;
    localparam int PACK_W = 3 * CB;
    localparam int RAD_W  = 16;
    localparam int R2W    = 2 * RAD_W;

    localparam int DW   = CB + 1;          // coordinate difference
    localparam int SQW  = 2 * DW + 2;      // dot of two differences
    localparam int XW   = 2 * DW + 1;      // cross of two differences
    localparam int SW   = XW + DW + 2;     // normal dot difference
    localparam int NNW  = 2 * XW + 2;      // dot of two cross products
    localparam int SH   = SW / 2;          // low split of |s|
    localparam int SHH  = SW - SH;         // high split of |s|
    localparam int SSW  = 2 * SW;          // s squared
    localparam int CH   = NNW / 3;         // chunk of nn for r2*nn
    localparam int RNW  = R2W + NNW;       // r2 times nn
    localparam int R2LW = R2W + 1 + SQW;   // r2 times edge length squared

    localparam logic [1:0] CAUSE_NONE   = 2'd0;
    localparam logic [1:0] CAUSE_VERTEX = 2'd1;
    localparam logic [1:0] CAUSE_INSIDE = 2'd2;
    localparam logic [1:0] CAUSE_EDGE   = 2'd3;

endpackage

// ----- rtl/sphere_triangle_intersect_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sphere_triangle_intersect_core
// Exact sphere / closed triangle intersection test, six pipeline stages.
// ============================================================================
// One triangle/sphere word enters per cycle while the output is not stalled;
// throughput is then one word per clock, set by the fully pipelined
// multiplier array (differences, cross products, dot products, split wide
// squares, wide compare). A stall at the output freezes the whole pipe.
// Coordinates are signed CB-bit fixed point packed x, y, z from bit 0; the
// radius is unsigned with the same fraction bits. Results: intersects and a
// cause code (none, vertex inside, projection inside, edge close).
module sphere_triangle_intersect_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [sti_pkg::PACK_W-1:0] vertex_a,
    input  logic [sti_pkg::PACK_W-1:0] vertex_b,
    input  logic [sti_pkg::PACK_W-1:0] vertex_c,
    input  logic [sti_pkg::PACK_W-1:0] center,
    input  logic [sti_pkg::RAD_W-1:0]  radius,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       intersects,
    output logic [1:0]                 cause
);
    import sti_pkg::*;

    logic en;
    logic [5:0] vld_reg, vld_next;

    // stage 1
    logic [R2W-1:0] r2_1_reg, r2_1_next;
    // stage 2
    logic signed [SQW-1:0] qq_reg [3], qq_next [3];
    logic signed [SQW-1:0] ll_reg [3], ll_next [3];
    logic signed [SQW-1:0] dp_reg [3], dp_next [3];
    logic [R2W-1:0] r2_2_reg, r2_2_next;
    // stage 3
    logic vhit3_reg, vhit3_next;
    logic signed [SW-1:0] s_reg, s_next;
    logic signed [NNW-1:0] nn_reg, nn_next;
    logic [2:0] neg_reg, neg_next;
    logic [2:0] near_reg, near_next;
    logic signed [NNW-1:0] xx3_reg [3], xx3_next [3];
    logic signed [SQW-1:0] ll3_reg [3], ll3_next [3];
    logic signed [SQW-1:0] dp3_reg [3], dp3_next [3];
    logic [R2W-1:0] r2_3_reg, r2_3_next;
    // stage 4
    logic vhit4_reg, vhit4_next;
    logic inside4_reg, inside4_next;
    logic nz4_reg, nz4_next;
    logic [2*SHH-1:0] phh_reg, phh_next;
    logic [SH+SHH-1:0] phl_reg, phl_next;
    logic [2*SH-1:0] pll_reg, pll_next;
    logic [R2W+CH-1:0] prn_reg [3], prn_next [3];
    logic [2:0] eres_reg, eres_next;
    logic [2:0] eint_reg, eint_next;
    logic signed [NNW-1:0] xx4_reg [3], xx4_next [3];
    logic signed [R2LW-1:0] r2ll_reg [3], r2ll_next [3];
    // stage 5
    logic vhit5_reg, vhit5_next;
    logic inside5_reg, inside5_next;
    logic edge5_reg, edge5_next;
    logic [SSW-1:0] ss_reg, ss_next;
    logic [RNW-1:0] rn_reg, rn_next;
    // stage 6 (output)
    logic hit_reg, hit_next;
    logic [1:0] cause_reg, cause_next;

    logic signed [CB-1:0] vc [3][3];
    logic signed [CB-1:0] cc [3];
    logic [PACK_W-1:0] vin [3];

    assign en       = !vld_reg[5] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[4:0], in_valid};

    assign vin[0] = vertex_a;
    assign vin[1] = vertex_b;
    assign vin[2] = vertex_c;

    // stage 1: unpack and take differences
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cc[i] = $signed(center[i*CB +: CB]);
            for (int k = 0; k < 3; k++)
            begin
                vc[i][k] = $signed(vin[i][k*CB +: CB]);
            end
        end
        r2_1_next = radius * radius;
    end

    // per-vertex vectors: q[i][axis], ed[i][axis]
    logic signed [DW-1:0] qv_reg [3][3], qv_next [3][3];
    logic signed [DW-1:0] ev_reg [3][3], ev_next [3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                qv_next[i][k] = DW'(cc[k]) - DW'(vc[i][k]);
                ev_next[i][k] = DW'(vc[(i == 2) ? 0 : i + 1][k]) - DW'(vc[i][k]);
            end
        end
    end

    // stage 2: products of differences
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qq_next[i] = qv_reg[i][0] * qv_reg[i][0] + qv_reg[i][1] * qv_reg[i][1]
                       + qv_reg[i][2] * qv_reg[i][2];
            ll_next[i] = ev_reg[i][0] * ev_reg[i][0] + ev_reg[i][1] * ev_reg[i][1]
                       + ev_reg[i][2] * ev_reg[i][2];
            dp_next[i] = qv_reg[i][0] * ev_reg[i][0] + qv_reg[i][1] * ev_reg[i][1]
                       + qv_reg[i][2] * ev_reg[i][2];
        end
        r2_2_next = r2_1_reg;
    end

    logic signed [XW-1:0] xv_reg [3][3], xv_next [3][3];
    logic signed [XW-1:0] nv_reg [3], nv_next [3];
    logic signed [DW-1:0] q0v_reg [3], q0v_next [3];

    always_comb
    begin
        // x_i = ed_i cross q_i
        for (int i = 0; i < 3; i++)
        begin
            xv_next[i][0] = ev_reg[i][1] * qv_reg[i][2] - ev_reg[i][2] * qv_reg[i][1];
            xv_next[i][1] = ev_reg[i][2] * qv_reg[i][0] - ev_reg[i][0] * qv_reg[i][2];
            xv_next[i][2] = ev_reg[i][0] * qv_reg[i][1] - ev_reg[i][1] * qv_reg[i][0];
        end
        // plane normal (b-a) x (c-a) equals ed2 x ed0
        nv_next[0] = ev_reg[2][1] * ev_reg[0][2] - ev_reg[2][2] * ev_reg[0][1];
        nv_next[1] = ev_reg[2][2] * ev_reg[0][0] - ev_reg[2][0] * ev_reg[0][2];
        nv_next[2] = ev_reg[2][0] * ev_reg[0][1] - ev_reg[2][1] * ev_reg[0][0];
        for (int k = 0; k < 3; k++)
        begin
            q0v_next[k] = qv_reg[0][k];
        end
    end

    // stage 3: plane terms, inside signs, vertex test
    logic signed [NNW-1:0] nx [3];
    logic signed [SQW-1:0] r2s3;

    always_comb
    begin
        r2s3 = SQW'($signed({1'b0, r2_2_reg}));
        vhit3_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            near_next[i] = (qq_reg[i] <= r2s3);
            vhit3_next   = vhit3_next | near_next[i];
            nx[i] = nv_reg[0] * xv_reg[i][0] + nv_reg[1] * xv_reg[i][1]
                  + nv_reg[2] * xv_reg[i][2];
            neg_next[i] = nx[i][NNW-1];
            xx3_next[i] = xv_reg[i][0] * xv_reg[i][0] + xv_reg[i][1] * xv_reg[i][1]
                        + xv_reg[i][2] * xv_reg[i][2];
            ll3_next[i] = ll_reg[i];
            dp3_next[i] = dp_reg[i];
        end
        s_next  = nv_reg[0] * q0v_reg[0] + nv_reg[1] * q0v_reg[1] + nv_reg[2] * q0v_reg[2];
        nn_next = nv_reg[0] * nv_reg[0] + nv_reg[1] * nv_reg[1] + nv_reg[2] * nv_reg[2];
        r2_3_next = r2_2_reg;
    end

    // stage 4: split wide products, edge case selection
    logic [SW-1:0] abs_s;
    logic [SH-1:0] s_lo;
    logic [SHH-1:0] s_hi;

    always_comb
    begin
        abs_s = s_reg[SW-1] ? SW'(-s_reg) : SW'(s_reg);
        s_lo  = abs_s[SH-1:0];
        s_hi  = abs_s[SW-1:SH];
        phh_next = (2*SHH)'(s_hi) * (2*SHH)'(s_hi);
        phl_next = (SH+SHH)'(s_hi) * (SH+SHH)'(s_lo);
        pll_next = (2*SH)'(s_lo) * (2*SH)'(s_lo);
        for (int k = 0; k < 3; k++)
        begin
            prn_next[k] = (R2W+CH)'(r2_3_reg) * (R2W+CH)'(nn_reg[k*CH +: CH]);
        end
        nz4_next     = (nn_reg != '0);
        inside4_next = ~|neg_reg;
        vhit4_next   = vhit3_reg;
        for (int i = 0; i < 3; i++)
        begin
            xx4_next[i]  = xx3_reg[i];
            r2ll_next[i] = $signed({1'b0, r2_3_reg}) * ll3_reg[i];
            // zero-length edge or center behind start: nearest point is start
            if (ll3_reg[i] == '0 || dp3_reg[i] <= 0)
            begin
                eres_next[i] = near_reg[i];
                eint_next[i] = 1'b0;
            end
            else if (dp3_reg[i] >= ll3_reg[i])
            begin
                eres_next[i] = near_reg[(i == 2) ? 0 : i + 1];
                eint_next[i] = 1'b0;
            end
            else
            begin
                eres_next[i] = 1'b0;
                eint_next[i] = 1'b1;
            end
        end
    end

    // stage 5: assemble squares, edge decisions
    always_comb
    begin
        ss_next = SSW'({phh_reg, {(2*SH){1'b0}}}) + SSW'({phl_reg, {(SH+1){1'b0}}})
                + SSW'(pll_reg);
        rn_next = RNW'(prn_reg[0]) + RNW'({prn_reg[1], {CH{1'b0}}})
                + RNW'({prn_reg[2], {(2*CH){1'b0}}});
        edge5_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (eint_reg[i])
            begin
                edge5_next = edge5_next | (NNW'(xx4_reg[i]) <= NNW'(r2ll_reg[i]));
            end
            else
            begin
                edge5_next = edge5_next | eres_reg[i];
            end
        end
        vhit5_next   = vhit4_reg;
        inside5_next = inside4_reg && nz4_reg;
    end

    // stage 6: plane compare and final priority
    always_comb
    begin
        hit_next   = 1'b0;
        cause_next = CAUSE_NONE;
        if (vhit5_reg)
        begin
            hit_next   = 1'b1;
            cause_next = CAUSE_VERTEX;
        end
        else if (ss_reg <= SSW'(rn_reg))
        begin
            if (inside5_reg)
            begin
                hit_next   = 1'b1;
                cause_next = CAUSE_INSIDE;
            end
            else if (edge5_reg)
            begin
                hit_next   = 1'b1;
                cause_next = CAUSE_EDGE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qv_reg    <= qv_next;
            ev_reg    <= ev_next;
            r2_1_reg  <= r2_1_next;
            qq_reg    <= qq_next;
            ll_reg    <= ll_next;
            dp_reg    <= dp_next;
            xv_reg    <= xv_next;
            nv_reg    <= nv_next;
            q0v_reg   <= q0v_next;
            r2_2_reg  <= r2_2_next;
            vhit3_reg <= vhit3_next;
            s_reg     <= s_next;
            nn_reg    <= nn_next;
            neg_reg   <= neg_next;
            near_reg  <= near_next;
            xx3_reg   <= xx3_next;
            ll3_reg   <= ll3_next;
            dp3_reg   <= dp3_next;
            r2_3_reg  <= r2_3_next;
            vhit4_reg <= vhit4_next;
            inside4_reg <= inside4_next;
            nz4_reg   <= nz4_next;
            phh_reg   <= phh_next;
            phl_reg   <= phl_next;
            pll_reg   <= pll_next;
            prn_reg   <= prn_next;
            eres_reg  <= eres_next;
            eint_reg  <= eint_next;
            xx4_reg   <= xx4_next;
            r2ll_reg  <= r2ll_next;
            vhit5_reg <= vhit5_next;
            inside5_reg <= inside5_next;
            edge5_reg <= edge5_next;
            ss_reg    <= ss_next;
            rn_reg    <= rn_next;
            hit_reg   <= hit_next;
            cause_reg <= cause_next;
        end
    end

    assign out_valid  = vld_reg[5];
    assign intersects = hit_reg;
    assign cause      = cause_reg;

endmodule

// ----- test/sphere_triangle_intersect_core_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sphere_triangle_intersect_core_tb
// Self-checking bench for the sphere / triangle intersection core.
// ============================================================================
// Directed words hit the field extremes, degenerate and zero-length-edge
// triangles, and each cause code. Random words follow, mostly placed so
// the sphere sits near the triangle, with some raw noise. Every accepted
// word is predicted with exact wide integer math and queued. Each output
// word is checked against the oldest entry. Both handshakes idle at random.
module sphere_triangle_intersect_core_tb;
    import sti_pkg::*;

    typedef logic signed [191:0] wide_t;
    typedef struct {
        longint x;
        longint y;
        longint z;
    } vec3_t;
    typedef struct {
        logic       hit;
        logic [1:0] why;
    } verdict_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [PACK_W-1:0] vertex_a;
    logic [PACK_W-1:0] vertex_b;
    logic [PACK_W-1:0] vertex_c;
    logic [PACK_W-1:0] center;
    logic [RAD_W-1:0]  radius;
    logic              out_valid;
    logic              out_ready;
    logic              intersects;
    logic [1:0]        cause;

    verdict_t verdicts_due[$];
    int       errors;
    int       cycles;
    bit       no_stall;

    localparam int CYCLE_LIMIT = 1000000;

    sphere_triangle_intersect_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .vertex_a   (vertex_a),
        .vertex_b   (vertex_b),
        .vertex_c   (vertex_c),
        .center     (center),
        .radius     (radius),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .intersects (intersects),
        .cause      (cause)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ---------------- geometry predictor ----------------
    function automatic vec3_t unpack3(logic [PACK_W-1:0] f);
        vec3_t v;
        v.x = longint'($signed(f[CB-1:0]));
        v.y = longint'($signed(f[2*CB-1:CB]));
        v.z = longint'($signed(f[3*CB-1:2*CB]));
        return v;
    endfunction

    function automatic vec3_t vsub(vec3_t p, vec3_t q);
        vec3_t r;
        r.x = p.x - q.x;
        r.y = p.y - q.y;
        r.z = p.z - q.z;
        return r;
    endfunction

    function automatic vec3_t vcross(vec3_t p, vec3_t q);
        vec3_t r;
        r.x = p.y * q.z - p.z * q.y;
        r.y = p.z * q.x - p.x * q.z;
        r.z = p.x * q.y - p.y * q.x;
        return r;
    endfunction

    function automatic longint vdot(vec3_t p, vec3_t q);
        return p.x * q.x + p.y * q.y + p.z * q.z;
    endfunction

    function automatic wide_t vdot_w(vec3_t p, vec3_t q);
        wide_t px, py, pz, qx, qy, qz;
        px = p.x; py = p.y; pz = p.z;
        qx = q.x; qy = q.y; qz = q.z;
        return px * qx + py * qy + pz * qz;
    endfunction

    function automatic bit segment_reached(vec3_t p, vec3_t q, vec3_t c, longint r2);
        vec3_t  ab, ap;
        longint ll, dp;
        wide_t  r2w, llw;
        ab = vsub(q, p);
        ap = vsub(c, p);
        ll = vdot(ab, ab);
        dp = vdot(ap, ab);
        if (ll == 0 || dp <= 0)
            return vdot(ap, ap) <= r2;
        if (dp >= ll)
            return vdot(vsub(c, q), vsub(c, q)) <= r2;
        r2w = r2;
        llw = ll;
        return vdot_w(vcross(ap, ab), vcross(ap, ab)) <= r2w * llw;
    endfunction

    function automatic verdict_t classify(logic [PACK_W-1:0] fa, logic [PACK_W-1:0] fb,
                                          logic [PACK_W-1:0] fc, logic [PACK_W-1:0] fs,
                                          logic [RAD_W-1:0] rad);
        vec3_t    v[3];
        vec3_t    c, n, ed;
        longint   r2;
        wide_t    s, nn, r2w;
        verdict_t res;
        bit       in_tri;
        v[0] = unpack3(fa);
        v[1] = unpack3(fb);
        v[2] = unpack3(fc);
        c = unpack3(fs);
        r2 = longint'(rad) * longint'(rad);
        r2w = r2;
        res.hit = 1'b0;
        res.why = CAUSE_NONE;
        for (int i = 0; i < 3 && !res.hit; i++)
            if (vdot(vsub(v[i], c), vsub(v[i], c)) <= r2)
            begin
                res.hit = 1'b1;
                res.why = CAUSE_VERTEX;
            end
        if (!res.hit)
        begin
            n = vcross(vsub(v[1], v[0]), vsub(v[2], v[0]));
            s = vdot_w(n, vsub(c, v[0]));
            nn = vdot_w(n, n);
            if (s * s <= r2w * nn)
            begin
                if (nn != 0)
                begin
                    in_tri = 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        ed = vsub(v[(i + 1) % 3], v[i]);
                        if (vdot_w(n, vcross(ed, vsub(c, v[i]))) < 0)
                            in_tri = 1'b0;
                    end
                    if (in_tri)
                    begin
                        res.hit = 1'b1;
                        res.why = CAUSE_INSIDE;
                    end
                end
                for (int i = 0; i < 3 && !res.hit; i++)
                    if (segment_reached(v[i], v[(i + 1) % 3], c, r2))
                    begin
                        res.hit = 1'b1;
                        res.why = CAUSE_EDGE;
                    end
            end
        end
        return res;
    endfunction

    // ---------------- handshake helpers ----------------
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_stall || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(logic [PACK_W-1:0] fa, logic [PACK_W-1:0] fb,
                             logic [PACK_W-1:0] fc, logic [PACK_W-1:0] fs,
                             logic [RAD_W-1:0] rad);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        vertex_a <= fa;
        vertex_b <= fb;
        vertex_c <= fc;
        center   <= fs;
        radius   <= rad;
        do @(posedge clk); while (!in_ready);
        verdicts_due = {verdicts_due, classify(fa, fb, fc, fs, rad)};
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= no_stall ? 1'b1 : ($urandom_range(0, 99) < 70);
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected word intersects=%0b cause=%0d",
                         $time, intersects, cause);
                errors++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (intersects !== want.hit)
                begin
                    $display("%0t: intersects expected %0b actual %0b",
                             $time, want.hit, intersects);
                    errors++;
                end
                if (cause !== want.why)
                begin
                    $display("%0t: cause expected %0d actual %0d",
                             $time, want.why, cause);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------
    function automatic logic [PACK_W-1:0] pack3(int x, int y, int z);
        logic [CB-1:0] px, py, pz;
        px = x[CB-1:0];
        py = y[CB-1:0];
        pz = z[CB-1:0];
        return {pz, py, px};
    endfunction

    function automatic int near(int base, int spread);
        int v;
        v = base + $urandom_range(0, 2 * spread) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    function automatic logic [PACK_W-1:0] rand_pack();
        return PACK_W'({$urandom(), $urandom()});
    endfunction

    task automatic test_extremes();
        logic [PACK_W-1:0] ones, mins, maxs;
        ones = '1;
        mins = pack3(-32768, -32768, -32768);
        maxs = pack3(32767, 32767, 32767);
        send_word('0, '0, '0, '0, '0);
        send_word(ones, ones, ones, ones, '1);
        send_word(mins, maxs, pack3(32767, -32768, 0), maxs, '0);
        send_word(mins, maxs, pack3(-32768, 32767, 32767), pack3(0, 0, 0), '1);
        send_word(maxs, mins, pack3(0, 32767, -32768), mins, 16'h0001);
        send_word(pack3(-32768, 0, 0), pack3(32767, 0, 0), pack3(0, 32767, 0),
                  pack3(0, 100, -32768), 16'hFFFF);
    endtask

    task automatic test_special_cases();
        // vertex exactly on the sphere surface
        send_word(pack3(300, 400, 0), pack3(5000, 0, 0), pack3(0, 5000, 0),
                  pack3(0, 0, 0), 16'd500);
        // plane too far away
        send_word(pack3(0, 0, 0), pack3(4000, 0, 0), pack3(0, 4000, 0),
                  pack3(1000, 1000, 700), 16'd600);
        // projection inside, plane exactly touching
        send_word(pack3(0, 0, 0), pack3(4000, 0, 0), pack3(0, 4000, 0),
                  pack3(1000, 1000, 600), 16'd600);
        // projection outside, edge close
        send_word(pack3(0, 0, 0), pack3(4000, 0, 0), pack3(0, 4000, 0),
                  pack3(2000, -300, 100), 16'd400);
        // projection outside, nothing close
        send_word(pack3(0, 0, 0), pack3(4000, 0, 0), pack3(0, 4000, 0),
                  pack3(3000, 3000, 100), 16'd400);
        // collinear triangle, center off the line
        send_word(pack3(0, 0, 0), pack3(1000, 1000, 1000), pack3(3000, 3000, 3000),
                  pack3(1500, 1500, 1800), 16'd300);
        send_word(pack3(0, 0, 0), pack3(1000, 1000, 1000), pack3(3000, 3000, 3000),
                  pack3(1500, 1500, 3000), 16'd300);
        // all three vertices equal
        send_word(pack3(-700, 20, 9), pack3(-700, 20, 9), pack3(-700, 20, 9),
                  pack3(-650, 20, 9), 16'd49);
        send_word(pack3(-700, 20, 9), pack3(-700, 20, 9), pack3(-700, 20, 9),
                  pack3(-650, 20, 9), 16'd50);
        // zero-length edge in a proper segment pair
        send_word(pack3(100, 100, 100), pack3(100, 100, 100), pack3(2000, 100, 100),
                  pack3(1000, 400, 100), 16'd300);
        // reversed winding, projection inside
        send_word(pack3(0, 0, 0), pack3(0, 4000, 0), pack3(4000, 0, 0),
                  pack3(800, 900, -200), 16'd250);
        // edge reached past an endpoint
        send_word(pack3(0, 0, 0), pack3(2000, 0, 0), pack3(0, 2000, 0),
                  pack3(2300, -100, 0), 16'd400);
    endtask

    task automatic test_random_near(int count);
        int bx, by, bz, sp, cs;
        logic [RAD_W-1:0] rad;
        for (int i = 0; i < count; i++)
        begin
            sp = ($urandom_range(0, 9) == 0) ? 30000 : $urandom_range(1, 3000);
            cs = $urandom_range(0, 3) == 0 ? 4 : sp;
            bx = near(0, 30000 - sp);
            by = near(0, 30000 - sp);
            bz = near(0, 30000 - sp);
            rad = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, sp));
            send_word(pack3(near(bx, sp), near(by, sp), near(bz, sp)),
                      pack3(near(bx, sp), near(by, sp), near(bz, sp)),
                      pack3(near(bx, cs), near(by, cs), near(bz, cs)),
                      pack3(near(bx, sp), near(by, sp), near(bz, sp)), rad);
        end
    endtask

    task automatic test_random_noise(int count);
        for (int i = 0; i < count; i++)
            send_word(rand_pack(), rand_pack(), rand_pack(), rand_pack(), 16'($urandom()));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        no_stall = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        vertex_a = '0;
        vertex_b = '0;
        vertex_c = '0;
        center = '0;
        radius = '0;
        out_ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_special_cases();
        test_random_near(700);
        // sender holds off until the pipe has emptied
        drain_results();
        no_stall = 1'b1;
        test_random_near(300);
        no_stall = 1'b0;
        test_random_noise(300);
        test_random_near(380);

        drain_results();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
